@@ rtl/asfm_pkg.sv @@
// ----------------------------------------------------------------------------
// asfm_pkg
// Shared types and constants for the ASCII set first-match finder.
// ----------------------------------------------------------------------------
package asfm_pkg;

  localparam int LANES_DEF      = 16;
  localparam int POS_BITS_DEF   = 32;
  localparam int WORD_W         = 64;
  localparam int COUNT_W        = 5;
  localparam int POS_W          = 32;
  localparam int SET_BITS       = 128;
  localparam int CHAR_W         = 7;
  localparam int LANE_IDX_W     = 4;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SET_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SET_HIGH = CFG_IDX_W'(1);

  typedef struct packed {
    logic [WORD_W-1:0]  chunk_low;
    logic [WORD_W-1:0]  chunk_high;
    logic [COUNT_W-1:0] valid_count;
    logic               last_chunk;
  } asfm_in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
  } asfm_out_t;

  typedef struct packed {
    logic                  hit;
    logic [LANE_IDX_W-1:0] idx;
  } asfm_pick_t;

  typedef struct packed {
    asfm_pick_t         pick;
    logic [COUNT_W-1:0] count;
    logic               last;
  } asfm_s1_t;

endpackage

@@ rtl/asfm_lane.sv @@
// ----------------------------------------------------------------------------
// asfm_lane
// Tests one byte of a chunk against the 128-entry character bitmap.
// ----------------------------------------------------------------------------
module asfm_lane
  import asfm_pkg::*;
(
  input  logic [7:0]          byte_in,
  input  logic                lane_en,
  input  logic [SET_BITS-1:0] char_set,
  output logic                hit
);

  logic [CHAR_W-1:0] code;

  assign code = byte_in[CHAR_W-1:0];
  assign hit  = lane_en & ~byte_in[7] & char_set[code];

endmodule

@@ rtl/asfm_merge.sv @@
// ----------------------------------------------------------------------------
// asfm_merge
// Priority pick of the lowest lane that reports a hit.
// ----------------------------------------------------------------------------
module asfm_merge
  import asfm_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  logic [LANES-1:0] hits,
  output asfm_pick_t       pick
);

  always_comb begin
    pick = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (hits[i]) begin
        pick.hit = 1'b1;
        pick.idx = LANE_IDX_W'(i);
      end
    end
  end

endmodule

@@ rtl/ascii_set_first_match_finder.sv @@
// ----------------------------------------------------------------------------
// ascii_set_first_match_finder
// Finds the first byte of a chunked string that lies in a 128-entry ASCII
// set; one result per string.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   in_     | input     | in_valid / in_ready    | asfm_in_t  (chunk)
//   out_    | output    | out_valid / out_ready  | asfm_out_t (result)
//   cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One chunk per cycle while the output is not stalled; a chunk's pick is held in the
// stage-one register, then its result in the output register. Stage one runs the lane
// tests and the priority pick, stage two the running count with its saturating add and
// the output register. Reset clears the count, the reported flag, both set registers
// and all valid flags; there is no clearing pass.
// A stalled output holds stage two; stage one still drains into it as it
// frees, so input stalls only while both stages are held.
// ----------------------------------------------------------------------------
module ascii_set_first_match_finder
  import asfm_pkg::*;
#(
  parameter int LANES         = LANES_DEF,
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  asfm_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output asfm_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  localparam int CNT_W = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;
  localparam logic [COUNT_W-1:0] LANE_CNT = COUNT_W'(LANES);

  logic [WORD_W-1:0]    set_low_r, set_high_r;
  logic [SET_BITS-1:0]  char_set;
  logic [2*WORD_W-1:0]  chunk;
  logic [COUNT_W-1:0]   count;
  logic [LANES-1:0]     hits;
  asfm_pick_t           pick;

  logic                 s1_valid_r, s1_valid_nxt;
  asfm_s1_t             s1_r;
  logic                 s2_adv;

  logic [CNT_W-1:0]     bytes_seen_r, bytes_seen_nxt;
  logic                 reported_r, reported_nxt;
  logic [COUNT_W-1:0]   addend;
  logic [CNT_W:0]       sum;
  logic [CNT_W-1:0]     sat;

  logic                 out_load;
  asfm_out_t            out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  asfm_out_t            out_data_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_low_r  <= '0;
      set_high_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SET_LOW:  set_low_r  <= cfg_data;
        REG_SET_HIGH: set_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign char_set = {set_high_r, set_low_r};
  assign chunk    = {in_data.chunk_high, in_data.chunk_low};
  assign count    = (in_data.valid_count > LANE_CNT) ? LANE_CNT : in_data.valid_count;

  // lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    asfm_lane u_lane (
      .byte_in  (chunk[8*g +: 8]),
      .lane_en  (COUNT_W'(g) < count),
      .char_set (char_set),
      .hit      (hits[g])
    );
  end

  asfm_merge #(.LANES(LANES)) u_merge (
    .hits (hits),
    .pick (pick)
  );

  // stage one
  assign s2_adv       = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready     = ~s1_valid_r | s2_adv;
  assign s1_valid_nxt = (in_valid & in_ready) | (s1_valid_r & ~s2_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r.pick  <= pick;
      s1_r.count <= count;
      s1_r.last  <= in_data.last_chunk;
    end
  end

  // stage two: running count and result
  assign addend = s1_r.pick.hit ? COUNT_W'(s1_r.pick.idx) : s1_r.count;
  assign sum    = {1'b0, bytes_seen_r} + (CNT_W + 1)'(addend);
  assign sat    = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    reported_nxt   = reported_r;
    out_load       = 1'b0;
    out_nxt        = '0;
    if (s2_adv) begin
      priority if (reported_r) begin
        if (s1_r.last) begin
          bytes_seen_nxt = '0;
          reported_nxt   = 1'b0;
        end
      end else if (s1_r.pick.hit) begin
        out_load         = 1'b1;
        out_nxt.position = POS_W'(sat);
        out_nxt.found    = 1'b1;
        if (s1_r.last) begin
          bytes_seen_nxt = '0;
          reported_nxt   = 1'b0;
        end else begin
          reported_nxt   = 1'b1;
        end
      end else begin
        bytes_seen_nxt = sat;
        if (s1_r.last) begin
          out_load         = 1'b1;
          out_nxt.position = POS_W'(sat);
          out_nxt.found    = 1'b0;
          bytes_seen_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      reported_r   <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      reported_r   <= reported_nxt;
    end
  end

  // output register
  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_no_result_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv && reported_r |-> !out_load)
    else $error("result given for a string already reported");

  a_miss_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !out_nxt.found |-> s1_r.last)
    else $error("not-found result before the last chunk");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv && s1_r.last |=> bytes_seen_r == '0 && !reported_r)
    else $error("string state not cleared after last chunk");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input held while a stage is free");
`endif

endmodule

@@ tb/tb_ascii_set_first_match_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_set_first_match_finder
// Streams chunked strings into the first-match finder and checks every result
// against a scoreboard model of the character-set search. A short directed
// list covers the edge cases, then random strings run under a range of set
// bitmaps and idle patterns on the request and result channels.
// ----------------------------------------------------------------------------
module tb_ascii_set_first_match_finder;
  import asfm_pkg::*;

  localparam longint unsigned POS_CAP = (POS_BITS_DEF >= 32) ? 64'hFFFF_FFFF :
                                        (64'd1 << POS_BITS_DEF) - 1;
  localparam logic [7:0] PLAIN = 8'h61;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  asfm_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  asfm_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SET_LOW;
  logic [WORD_W-1:0]    cfg_data = '0;

  asfm_in_t         chunks_waiting[$];
  asfm_out_t        results_due[$];
  asfm_out_t        want_result;
  int               chunks_in_flight = 0;
  int               error_count = 0;
  int               send_idle = 0;
  int               recv_idle = 0;
  logic [127:0]     char_set = '0;
  longint unsigned  run_bytes = 0;
  bit               string_done = 1'b0;

  ascii_set_first_match_finder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_ascii_set_first_match_finder NOT OK");
    $finish;
  end

  function automatic bit char_in_set(logic [7:0] c);
    return !c[7] && char_set[c[6:0]];
  endfunction

  function automatic longint unsigned sat_pos(longint unsigned x);
    return (x > POS_CAP) ? POS_CAP : x;
  endfunction

  function automatic void clear_string();
    run_bytes = 0;
    string_done = 1'b0;
  endfunction

  function automatic void scan_chunk(asfm_in_t c);
    logic [127:0] lanes;
    int           n;
    int           hit;
    asfm_out_t    r;
    lanes = {c.chunk_high, c.chunk_low};
    n = (c.valid_count > LANES_DEF) ? LANES_DEF : int'(c.valid_count);
    hit = -1;
    if (string_done) begin
      if (c.last_chunk) clear_string();
      return;
    end
    for (int i = n - 1; i >= 0; i--) begin
      if (char_in_set(lanes[8*i +: 8])) hit = i;
    end
    if (hit >= 0) begin
      r.position = POS_W'(sat_pos(run_bytes + longint'(hit)));
      r.found = 1'b1;
      results_due.push_back(r);
      if (c.last_chunk) clear_string();
      else string_done = 1'b1;
    end else begin
      run_bytes = sat_pos(run_bytes + longint'(n));
      if (c.last_chunk) begin
        r.position = POS_W'(run_bytes);
        r.found = 1'b0;
        results_due.push_back(r);
        clear_string();
      end
    end
  endfunction

  function automatic asfm_in_t make_chunk(logic [7:0] fill, int lane, logic [7:0] ch,
                                          int count, bit last);
    logic [127:0] b;
    asfm_in_t     c;
    b = {16{fill}};
    if (lane >= 0) b[8*lane +: 8] = ch;
    c.chunk_low = b[63:0];
    c.chunk_high = b[127:64];
    c.valid_count = COUNT_W'(count);
    c.last_chunk = last;
    return c;
  endfunction

  function automatic void push_chunk(asfm_in_t c);
    chunks_waiting.push_back(c);
    chunks_in_flight++;
  endfunction

  function automatic logic [7:0] pick_byte(bit want_hit);
    logic [7:0] c;
    if (want_hit && char_set != '0) begin
      repeat (64) begin
        c = 8'($urandom_range(127));
        if (char_set[c[6:0]]) return c;
      end
      for (int i = 0; i < 128; i++) begin
        if (char_set[i]) return 8'(i);
      end
    end
    do begin
      c = 8'($urandom_range(255));
    end while (char_in_set(c));
    return c;
  endfunction

  function automatic int push_string();
    int           n_chunks;
    int           den;
    int           n;
    logic [127:0] b;
    asfm_in_t     c;
    n_chunks = $urandom_range(1, 6);
    case ($urandom_range(4))
      0: den = 2;
      1: den = 6;
      2: den = 24;
      3: den = 96;
      default: den = 0;
    endcase
    for (int k = 0; k < n_chunks; k++) begin
      for (int i = 0; i < 16; i++) begin
        b[8*i +: 8] = pick_byte(den != 0 && $urandom_range(den - 1) == 0);
      end
      if ($urandom_range(15) == 0) n = $urandom_range(17, 31);
      else if (k < n_chunks - 1 && $urandom_range(3) != 0) n = 16;
      else n = $urandom_range(16);
      c.chunk_low = b[63:0];
      c.chunk_high = b[127:64];
      c.valid_count = COUNT_W'(n);
      c.last_chunk = (k == n_chunks - 1);
      push_chunk(c);
    end
    return n_chunks;
  endfunction

  function automatic asfm_in_t noise_chunk();
    asfm_in_t c;
    c.chunk_low = {$urandom, $urandom};
    c.chunk_high = {$urandom, $urandom};
    c.valid_count = COUNT_W'($urandom_range(31));
    c.last_chunk = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SET_LOW) char_set[63:0] = val;
    else if (idx == REG_SET_HIGH) char_set[127:64] = val;
  endtask

  task automatic wait_idle();
    while (chunks_in_flight != 0 || results_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_chunk(in_data);
        chunks_in_flight--;
      end
      if (!in_valid || in_ready) begin
        if (chunks_waiting.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_data <= chunks_waiting.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t unexpected result: expected none, got position %0d found %0b",
                   $time, out_data.position, out_data.found);
          error_count++;
        end else begin
          want_result = results_due.pop_front();
          if (out_data.position !== want_result.position) begin
            $display("%0t position mismatch: expected %0d, got %0d",
                     $time, want_result.position, out_data.position);
            error_count++;
          end
          if (out_data.found !== want_result.found) begin
            $display("%0t found mismatch: expected %0b, got %0b",
                     $time, want_result.found, out_data.found);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    logic [127:0]      sparse;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    int                made;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 36;
    recv_idle = 64;

    // set: NUL, space, comma, 'z', DEL
    write_reg(REG_SET_LOW, (64'd1 << 0) | (64'd1 << 32) | (64'd1 << 44));
    write_reg(REG_SET_HIGH, (64'd1 << 58) | (64'd1 << 63));

    push_chunk(make_chunk(8'h00, -1, 8'h00, 16, 1'b1));
    push_chunk(make_chunk(8'hFF, -1, 8'h00, 16, 1'b1));
    push_chunk(make_chunk(8'hA0, -1, 8'h00, 16, 1'b1));
    push_chunk(make_chunk(PLAIN, -1, 8'h00, 0, 1'b1));
    push_chunk(make_chunk(PLAIN, -1, 8'h00, 16, 1'b0));
    push_chunk(make_chunk(PLAIN, 15, 8'h7F, 16, 1'b1));
    push_chunk(make_chunk(PLAIN, 15, 8'h2C, 31, 1'b1));
    push_chunk(make_chunk(PLAIN, -1, 8'h00, 20, 1'b1));
    // hold off further results until the closing chunk
    push_chunk(make_chunk(PLAIN, 3, 8'h20, 16, 1'b0));
    push_chunk(make_chunk(PLAIN, 0, 8'h7A, 16, 1'b0));
    push_chunk(make_chunk(PLAIN, -1, 8'h00, 0, 1'b0));
    push_chunk(make_chunk(8'hFF, 0, 8'h00, 16, 1'b1));
    push_chunk(make_chunk(PLAIN, -1, 8'h00, 5, 1'b1));
    push_chunk(make_chunk(PLAIN, 10, 8'h20, 10, 1'b1));
    push_chunk(make_chunk(PLAIN, -1, 8'h00, 7, 1'b0));
    push_chunk(make_chunk(PLAIN, -1, 8'h00, 0, 1'b0));
    push_chunk(make_chunk(PLAIN, 2, 8'h7A, 3, 1'b1));
    push_chunk(make_chunk(PLAIN, 8, 8'h00, 16, 1'b1));

    for (int p = 0; p < 12; p++) begin
      wait_idle();
      if (p < 4) begin
        send_idle = 36;
        recv_idle = 64;
      end else if (p < 8) begin
        send_idle = 64;
        recv_idle = 36;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (p % 6)
        0: begin
          lo = '0;
          hi = '0;
        end
        1: begin
          lo = '1;
          hi = '1;
        end
        2: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
        3: begin
          sparse = '0;
          repeat (3) sparse[$urandom_range(127)] = 1'b1;
          lo = sparse[63:0];
          hi = sparse[127:64];
        end
        4: begin
          lo = {$urandom, $urandom};
          hi = '0;
        end
        default: begin
          lo = '0;
          hi = {$urandom, $urandom};
        end
      endcase
      write_reg(REG_SET_LOW, lo);
      write_reg(REG_SET_HIGH, hi);
      made = 0;
      while (made < 157) begin
        if ($urandom_range(9) == 0) begin
          push_chunk(noise_chunk());
          made++;
        end else begin
          made += push_string();
        end
      end
      // close any string left open by noise
      push_chunk(make_chunk(8'hFF, -1, 8'h00, 0, 1'b1));
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_ascii_set_first_match_finder OK");
    end else begin
      $display("tb_ascii_set_first_match_finder NOT OK");
    end
    $finish;
  end

endmodule
